@@ rtl/sct_pkg.sv @@
// Shared constants and types for the sector cache tag and clock policy engine.
package sct_pkg;

  localparam int ENTRIES  = 64;
  localparam int IDX_W    = $clog2(ENTRIES);

  localparam int OP_W     = 2;
  localparam int SECTOR_W = 32;
  localparam int ENTRY_W  = 6;

  // Output word: entry_index, then write_back_sector, padded to whole bytes.
  localparam int OUT_DATA_W = ((ENTRY_W + SECTOR_W + 7) / 8) * 8;
  localparam int IN_DATA_W  = ((SECTOR_W + 7) / 8) * 8;
  localparam int IN_USER_W  = OP_W;
  localparam int OUT_USER_W = 3;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOOKUP = 8'b0000_0010,
    S_HIT    = 8'b0000_0100,
    S_VSCAN  = 8'b0000_1000,
    S_VREAD  = 8'b0001_0000,
    S_VDATA  = 8'b0010_0000,
    S_FLSCAN = 8'b0100_0000,
    S_FLDATA = 8'b1000_0000
  } state_t;

endpackage

@@ rtl/sector_cache_clock_tags_top.sv @@
// Top level of the sector cache tag store with second-chance clock replacement.
//
// Input channel (in_*): one word per request. in_tuser carries the operation
// (read, write or flush) and in_tdata the sector number. Code 3 is dropped.
// Output channel (out_*): one word per result. A read or write gives one
// word; a flush gives one word per dirty entry in index order, or a single
// all-zero word when nothing is dirty. out_tlast marks a request's final word.
// Requests are handled one at a time. A lookup streams the tag RAM, one entry
// per cycle, until a hit or the last entry. A miss adds the clock scan over
// the flag registers, one entry per cycle, which at worst makes a pass that
// clears every reference bit and then stops on entry 0 again, plus a tag RAM
// read of the victim. A flush scans up to the last dirty entry, reading the
// tag RAM for each dirty entry, or all entries when nothing is dirty. The tag
// RAM port is the limit of the lookup.
// Reset clears the valid, reference and dirty flags at once; the tag RAM is
// not cleared and its contents are used only for valid entries. A result waits in the
// output register while out_tready is low; the engine keeps working on the
// current request and only stalls when it has the next word ready.
module sector_cache_clock_tags_top
  import sct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] sector
  input  logic [IN_USER_W-1:0]  in_tuser,   // [1:0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [5:0] entry_index, [37:6] write_back_sector
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] hit, [1] write_back, [2] fill
  output logic                  out_tlast
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] ref_r, ref_nxt;
  logic [ENTRIES-1:0] dirty_r, dirty_nxt;

  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] ent_idx_r, ent_idx_nxt;
  logic             issue_done_r, issue_done_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [SECTOR_W-1:0] sector_r, sector_nxt;
  logic             is_write_r, is_write_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_wb_r, out_wb_nxt;
  logic [SECTOR_W-1:0] out_wbs_r, out_wbs_nxt;
  logic                out_fill_r, out_fill_nxt;
  logic                out_last_r, out_last_nxt;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_addr;
  logic [SECTOR_W-1:0] ram_rdata;

  logic in_fire, out_free, more_dirty;
  logic [ENTRIES-1:0] vd;

  sct_ram #(
    .WIDTH (SECTOR_W),
    .DEPTH (ENTRIES)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (sector_r),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign vd        = valid_r & dirty_r;

  // Is any valid dirty entry left above the one being flushed?
  always_comb begin
    more_dirty = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (IDX_W'(j) > ent_idx_r && vd[j]) begin
        more_dirty = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    ref_nxt        = ref_r;
    dirty_nxt      = dirty_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    ent_idx_nxt    = ent_idx_r;
    issue_done_nxt = issue_done_r;
    cmp_v_nxt      = 1'b0;
    sector_nxt     = sector_r;
    is_write_nxt   = is_write_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_hit_nxt    = out_hit_r;
    out_idx_nxt    = out_idx_r;
    out_wb_nxt     = out_wb_r;
    out_wbs_nxt    = out_wbs_r;
    out_fill_nxt   = out_fill_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_addr       = ent_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sector_nxt     = in_tdata[SECTOR_W-1:0];
          is_write_nxt   = (in_tuser == OP_WRITE);
          scan_idx_nxt   = '0;
          issue_done_nxt = 1'b0;
          ent_idx_nxt    = '0;
          if (in_tuser == OP_READ || in_tuser == OP_WRITE) begin
            state_nxt = S_LOOKUP;
          end else if (in_tuser == OP_FLUSH) begin
            state_nxt = S_FLSCAN;
          end
        end
      end

      // Tag reads stream one per cycle; the compare follows in the cycle after each read.
      S_LOOKUP: begin
        ram_addr    = scan_idx_r;
        ram_re      = !issue_done_r;
        cmp_v_nxt   = !issue_done_r;
        cmp_idx_nxt = scan_idx_r;
        if (!issue_done_r) begin
          if (scan_idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (cmp_v_r && valid_r[cmp_idx_r] && ram_rdata == sector_r) begin
          ent_idx_nxt = cmp_idx_r;
          cmp_v_nxt   = 1'b0;
          state_nxt   = S_HIT;
        end else if (cmp_v_r && cmp_idx_r == LAST_IDX) begin
          ent_idx_nxt = '0;
          state_nxt   = S_VSCAN;
        end
      end

      S_HIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b1;
          out_idx_nxt   = ent_idx_r;
          out_wb_nxt    = 1'b0;
          out_wbs_nxt   = '0;
          out_fill_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          ref_nxt[ent_idx_r] = 1'b1;
          if (is_write_r) begin
            dirty_nxt[ent_idx_r] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      // Second chance: a referenced entry loses its bit and the hand moves on.
      S_VSCAN: begin
        if (!valid_r[ent_idx_r] || !ref_r[ent_idx_r]) begin
          state_nxt = S_VREAD;
        end else begin
          ref_nxt[ent_idx_r] = 1'b0;
          ent_idx_nxt = (ent_idx_r == LAST_IDX) ? '0 : ent_idx_r + 1'b1;
        end
      end

      S_VREAD: begin
        ram_re    = 1'b1;
        state_nxt = S_VDATA;
      end

      S_VDATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_idx_nxt   = ent_idx_r;
          out_wb_nxt    = vd[ent_idx_r];
          out_wbs_nxt   = vd[ent_idx_r] ? ram_rdata : '0;
          out_fill_nxt  = 1'b1;
          out_last_nxt  = 1'b1;
          ram_we        = 1'b1;
          valid_nxt[ent_idx_r] = 1'b1;
          ref_nxt[ent_idx_r]   = 1'b1;
          dirty_nxt[ent_idx_r] = is_write_r;
          state_nxt = S_IDLE;
        end
      end

      S_FLSCAN: begin
        if (vd[ent_idx_r]) begin
          ram_re    = 1'b1;
          state_nxt = S_FLDATA;
        end else if (ent_idx_r == LAST_IDX) begin
          // Reaching the end here means nothing was dirty.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_hit_nxt   = 1'b0;
            out_idx_nxt   = '0;
            out_wb_nxt    = 1'b0;
            out_wbs_nxt   = '0;
            out_fill_nxt  = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          ent_idx_nxt = ent_idx_r + 1'b1;
        end
      end

      S_FLDATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_idx_nxt   = ent_idx_r;
          out_wb_nxt    = 1'b1;
          out_wbs_nxt   = ram_rdata;
          out_fill_nxt  = 1'b0;
          out_last_nxt  = !more_dirty;
          dirty_nxt[ent_idx_r] = 1'b0;
          if (more_dirty) begin
            ent_idx_nxt = ent_idx_r + 1'b1;
            state_nxt   = S_FLSCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      ref_r       <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      ref_r       <= ref_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    ent_idx_r    <= ent_idx_nxt;
    issue_done_r <= issue_done_nxt;
    sector_r     <= sector_nxt;
    is_write_r   <= is_write_nxt;
    out_hit_r    <= out_hit_nxt;
    out_idx_r    <= out_idx_nxt;
    out_wb_r     <= out_wb_nxt;
    out_wbs_r    <= out_wbs_nxt;
    out_fill_r   <= out_fill_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_wbs_r, ENTRY_W'(out_idx_r)});
  assign out_tuser  = {out_fill_r, out_wb_r, out_hit_r};
  assign out_tlast  = out_last_r;

  // A hit always points at a valid entry.
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HIT) |-> valid_r[ent_idx_r])
    else $error("hit on an invalid entry");

  // The clock hand stops only on an invalid or unreferenced entry.
  a_victim_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VDATA) |-> (!valid_r[ent_idx_r] || !ref_r[ent_idx_r]))
    else $error("victim still referenced");

  // A flush result is only produced for a valid dirty entry.
  a_flush_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLDATA) |-> vd[ent_idx_r])
    else $error("flushing a clean entry");

  // A new word is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_last_r)))
    else $error("pending result overwritten");

  // A read, write or flush request always leaves idle.
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser == OP_READ || in_tuser == OP_WRITE || in_tuser == OP_FLUSH))
    |=> (state_r != S_IDLE))
    else $error("request not started");

endmodule

@@ rtl/sct_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
module sct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the sector cache tag store with clock replacement.
module tb_top;
  import sct_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 90;
  localparam int HOT_N        = 12;
  localparam int PHASE_A      = 45;
  localparam int PHASE_B      = 90;
  localparam int HOLD_AT      = 30;
  localparam int HOLD_LEN     = 400;
  localparam int TAIL_CYCLES  = 260;
  localparam int STALL_LIMIT  = 3000;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SECTOR_W-1:0] sector;
    logic                drain;
  } request_t;

  typedef struct packed {
    logic                hit;
    logic [ENTRY_W-1:0]  entry;
    logic                wb;
    logic [SECTOR_W-1:0] wb_sector;
    logic                fill;
    logic                last;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [31:0] sector
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [1:0] operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [5:0] entry_index, [37:6] write_back_sector
  logic [OUT_USER_W-1:0] out_tuser;       // [0] hit, [1] write_back, [2] fill
  logic                  out_tlast;

  // Mirror of the cache state as the block should hold it.
  logic [SECTOR_W-1:0] tag_mem      [ENTRIES];
  logic                mirror_valid [ENTRIES];
  logic                ref_bit      [ENTRIES];
  logic                mirror_dirty [ENTRIES];

  request_t request_queue[$];
  outcome_t due_results[$];
  request_t offered = '0;
  int       sent_cnt = 0;
  int       err_count = 0;
  int       hold_cnt = 0;
  logic     hold_done = 1'b0;
  int       quiet_cycles = 0;

  sector_cache_clock_tags_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic outcome_t make_outcome(logic hit, int entry, logic wb,
                                            logic [SECTOR_W-1:0] wbs, logic fill,
                                            logic last);
    outcome_t o;
    o.hit       = hit;
    o.entry     = entry[ENTRY_W-1:0];
    o.wb        = wb;
    o.wb_sector = wbs;
    o.fill      = fill;
    o.last      = last;
    return o;
  endfunction

  // Updates the mirrored state for one accepted word and queues its results.
  function automatic void cache_predict(request_t r);
    int       i;
    int       victim;
    int       first;
    logic     wb;
    outcome_t flushed[$];
    if (r.op == OP_UNUSED) return;
    if (r.op == OP_FLUSH) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (mirror_valid[i] && mirror_dirty[i]) begin
          flushed.push_back(make_outcome(1'b0, i, 1'b1, tag_mem[i], 1'b0, 1'b0));
          mirror_dirty[i] = 1'b0;
        end
      end
      if (flushed.size() == 0)
        flushed.push_back(make_outcome(1'b0, 0, 1'b0, '0, 1'b0, 1'b1));
      else
        flushed[flushed.size()-1].last = 1'b1;
      foreach (flushed[k]) due_results.push_back(flushed[k]);
      return;
    end
    for (i = 0; i < ENTRIES; i++) begin
      if (mirror_valid[i] && tag_mem[i] == r.sector) begin
        ref_bit[i] = 1'b1;
        if (r.op == OP_WRITE) mirror_dirty[i] = 1'b1;
        due_results.push_back(make_outcome(1'b1, i, 1'b0, '0, 1'b0, 1'b1));
        return;
      end
    end
    // Second chance: the hand always starts at entry 0 and clears reference
    // bits until it finds an empty or unreferenced entry.
    victim = -1;
    i = 0;
    first = 0;
    while (victim < 0 && first < 2 * ENTRIES + 2) begin
      if (!mirror_valid[i] || !ref_bit[i]) begin
        victim = i;
      end else begin
        ref_bit[i] = 1'b0;
        i = (i + 1) % ENTRIES;
      end
      first++;
    end
    if (victim < 0) victim = i;
    wb = mirror_valid[victim] && mirror_dirty[victim];
    due_results.push_back(make_outcome(1'b0, victim, wb, wb ? tag_mem[victim] : '0,
                                       1'b1, 1'b1));
    tag_mem[victim]      = r.sector;
    mirror_valid[victim] = 1'b1;
    mirror_dirty[victim] = (r.op == OP_WRITE);
    ref_bit[victim]      = 1'b1;
  endfunction

  task automatic queue_request(logic [OP_W-1:0] op, logic [SECTOR_W-1:0] sector,
                               logic drain);
    request_t r;
    r.op     = op;
    r.sector = sector;
    r.drain  = drain;
    request_queue.push_back(r);
  endtask

  task automatic check_field(string name, logic [SECTOR_W-1:0] want,
                             logic [SECTOR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // Sender: offers queued words, idling at random depending on the phase.
  always @(posedge clk) begin : drive
    request_t nxt;
    int       gap_pct;
    gap_pct = (sent_cnt < PHASE_A) ? 15 : (sent_cnt < PHASE_B) ? 72 : 0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        cache_predict(offered);
        sent_cnt <= sent_cnt + 1;
      end
      if (in_tvalid && !in_tready) begin
        // The word stays on the bus until it is taken.
      end else if (request_queue.size() != 0 &&
                   !(request_queue[0].drain && due_results.size() != 0) &&
                   $urandom_range(99) >= gap_pct) begin
        nxt = request_queue.pop_front();
        offered   <= nxt;
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.sector;
        in_tuser  <= nxt.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off to fill the block.
  always @(posedge clk) begin : receive
    int stall_pct;
    stall_pct = (sent_cnt < PHASE_A) ? 72 : (sent_cnt < PHASE_B) ? 15 : 0;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_cnt   <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("unexpected word: tdata 0x%0h tuser 0x%0h tlast %0b",
               out_tdata, out_tuser, out_tlast);
        err_count++;
      end else begin
        want = due_results.pop_front();
        check_field("hit", SECTOR_W'(want.hit), SECTOR_W'(out_tuser[0]));
        check_field("entry_index", SECTOR_W'(want.entry),
                    SECTOR_W'(out_tdata[ENTRY_W-1:0]));
        check_field("write_back", SECTOR_W'(want.wb), SECTOR_W'(out_tuser[1]));
        check_field("write_back_sector", want.wb_sector,
                    out_tdata[ENTRY_W+SECTOR_W-1:ENTRY_W]);
        check_field("fill", SECTOR_W'(want.fill), SECTOR_W'(out_tuser[2]));
        check_field("last", SECTOR_W'(want.last), SECTOR_W'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [SECTOR_W-1:0] hot [HOT_N];
    request_t            r;
    int                  n;
    int                  roll;
    for (n = 0; n < ENTRIES; n++) begin
      tag_mem[n]      = '0;
      mirror_valid[n] = 1'b0;
      ref_bit[n]      = 1'b0;
      mirror_dirty[n] = 1'b0;
    end

    // Directed part: empty flush, hits and misses at the sector extremes,
    // dirty flush, repeated flush, ignored code 3.
    queue_request(OP_FLUSH,  32'h0000_0000, 1'b0);
    queue_request(OP_READ,   32'h0000_0000, 1'b0);
    queue_request(OP_READ,   32'h0000_0000, 1'b0);
    queue_request(OP_WRITE,  32'hFFFF_FFFF, 1'b0);
    queue_request(OP_WRITE,  32'h0000_0000, 1'b0);
    queue_request(OP_READ,   32'hFFFF_FFFF, 1'b0);
    queue_request(OP_UNUSED, 32'h1234_5678, 1'b0);
    queue_request(OP_WRITE,  32'hAAAA_AAAA, 1'b0);
    queue_request(OP_WRITE,  32'h5555_5555, 1'b0);
    queue_request(OP_FLUSH,  32'h0000_0000, 1'b0);
    queue_request(OP_FLUSH,  32'h0000_0000, 1'b1);
    queue_request(OP_READ,   32'h5555_5555, 1'b0);
    queue_request(OP_WRITE,  32'h0000_0001, 1'b0);
    queue_request(OP_READ,   32'h8000_0000, 1'b0);
    queue_request(OP_FLUSH,  32'hFFFF_FFFF, 1'b0);
    queue_request(OP_UNUSED, 32'hFFFF_FFFF, 1'b0);
    queue_request(OP_WRITE,  32'h8000_0000, 1'b0);
    queue_request(OP_READ,   32'h1234_5678, 1'b0);

    // Random part: a small hot set for hits, fresh sectors to fill the
    // cache and force clock evictions of dirty entries.
    for (n = 0; n < HOT_N; n++) hot[n] = $urandom;
    hot[0] = '0;
    hot[1] = '1;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 4)
        r.op = OP_UNUSED;
      else if (roll < 12)
        r.op = OP_FLUSH;
      else if (roll < 57)
        r.op = OP_READ;
      else
        r.op = OP_WRITE;
      r.sector = ($urandom_range(99) < 45) ? hot[$urandom_range(HOT_N-1)] : $urandom;
      r.drain  = (n == 60);
      request_queue.push_back(r);
      if (r.op != OP_UNUSED) n++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sct_pkg.sv
rtl/sct_ram.sv
rtl/sector_cache_clock_tags_top.sv
tb/sv/tb_top.sv
